### hw/rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// Binary thinning sub-pass package
// Shared beat types, register indexes, size limits and ring order.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Field width of the size registers.
   localparam int SIZE_W = 11;
   // Counter width: holds a size plus the drain rows.
   localparam int CNT_W  = SIZE_W + 1;
   // Row store address width.
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CSR_W  = 2;

   localparam logic [CSR_W-1:0] CSR_SUB_ITERATION = 2'd0;
   localparam logic [CSR_W-1:0] CSR_IMAGE_WIDTH   = 2'd1;
   localparam logic [CSR_W-1:0] CSR_IMAGE_HEIGHT  = 2'd2;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
   localparam int                MIN_SIZE     = 4;

   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   // Window bit positions visited around the ring, starting at north.
   localparam logic [3:0] RING_POS [8] = '{4'd3, 4'd6, 4'd7, 4'd8,
                                           4'd5, 4'd2, 4'd1, 4'd0};
   localparam int POS_N = 3;
   localparam int POS_E = 7;
   localparam int POS_S = 5;
   localparam int POS_W = 1;
   localparam int POS_C = 4;

   typedef struct packed {
      logic action;
      logic pixel;
   } req_type;

   typedef struct packed {
      logic pixel_out;
      logic deleted;
      logic last;
      logic frame_changed;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/binary_thinning_subpass_top.sv
// ----------------------------------------------------------------------------
// Binary thinning sub-pass
// Latency: a result passes stage 1 and the output queue after the beat that
//   completes its 3x3 window; in stream terms results lag by width+1 beats.
// Throughput: one beat per cycle while the output queue has room, set by the
//   row store read at accept and its write-back in the following cycle.
// Reset: synchronous; counters, window, config and output queue are cleared,
//   the row store is not.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_thinning_subpass_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire bts_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output bts_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_we,
   input  wire logic [bts_pkg::CSR_W-1:0]  csr_index,
   input  wire logic [bts_pkg::SIZE_W-1:0] csr_wdata
);
   import bts_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   // configuration
   logic              sub_ff, sub_in;
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic              restart;
   logic [SIZE_W-1:0] clamped_w, clamped_h;

   // frame position
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] w_ext, h_ext, col_inc, er, ec;
   logic             accept, proc, in_frame, bit_in, wrap, emit, interior, last;

   // stage 1: row store read in flight
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_bit_ff, s1_emit_ff, s1_interior_ff, s1_last_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [1:0]       rd_ff;
   logic [1:0]       row_mem [MAX_WIDTH];

   // stage 2: window and decision
   logic [8:0] win_ff, win_in;
   logic       any_ff, any_in;
   logic [7:0] ring;
   logic [3:0] trans, ones;
   logic       centre, prod1, prod2, del, push;
   rsp_type    push_data;

   // output queue
   rsp_type          fifo [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             pop;

   // ---------------- configuration ----------------
   always_comb begin
      clamped_w = csr_wdata;
      if (32'(csr_wdata) < MIN_SIZE) clamped_w = SIZE_W'(MIN_SIZE);
      else if (32'(csr_wdata) > MAX_WIDTH) clamped_w = SIZE_W'(MAX_WIDTH);
      clamped_h = csr_wdata;
      if (32'(csr_wdata) < MIN_SIZE) clamped_h = SIZE_W'(MIN_SIZE);
      else if (32'(csr_wdata) > MAX_HEIGHT) clamped_h = SIZE_W'(MAX_HEIGHT);

      sub_in    = sub_ff;
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_SUB_ITERATION: sub_in = csr_wdata[0];
            CSR_IMAGE_WIDTH: begin
               width_in = clamped_w;
               restart  = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = clamped_h;
               restart   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // ---------------- accept and position ----------------
   always_comb begin
      w_ext     = CNT_W'(width_ff);
      h_ext     = CNT_W'(height_ff);
      req_ready = (cnt_ff + (PTR_W+1)'(s1_valid_ff)) < (PTR_W+1)'(DEPTH);
      accept    = req_valid && req_ready;
      in_frame  = row_ff < h_ext;
      proc      = accept && !(in_frame && (req_data.action == ACTION_DRAIN));
      bit_in    = in_frame & req_data.pixel;

      col_inc = col_ff + CNT_W'(1);
      wrap    = col_inc >= w_ext;
      emit    = (row_ff >= CNT_W'(2)) || ((row_ff == CNT_W'(1)) && (col_ff != '0));
      if (col_ff != '0) begin
         er = row_ff - CNT_W'(1);
         ec = col_ff - CNT_W'(1);
      end else begin
         er = row_ff - CNT_W'(2);
         ec = w_ext - CNT_W'(1);
      end
      interior = (er >= CNT_W'(1)) && ((er + CNT_W'(2)) <= h_ext)
               && (ec >= CNT_W'(1)) && ((ec + CNT_W'(2)) <= w_ext);
      last     = emit && (er == h_ext - CNT_W'(1)) && (ec == w_ext - CNT_W'(1));

      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (proc) begin
         if (last) begin
            row_in = '0;
            col_in = '0;
         end else if (wrap) begin
            row_in = row_ff + CNT_W'(1);
            col_in = '0;
         end else begin
            col_in = col_inc;
         end
      end
      s1_valid_in = proc;
   end

   // ---------------- row store ----------------
   always_ff @(posedge clock) begin
      if (s1_valid_ff) row_mem[s1_col_ff] <= {rd_ff[0], s1_bit_ff};
      if (proc) begin
         if (s1_valid_ff && (s1_col_ff == col_ff[COL_W-1:0])) rd_ff <= {rd_ff[0], s1_bit_ff};
         else rd_ff <= row_mem[col_ff[COL_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         s1_bit_ff      <= bit_in;
         s1_emit_ff     <= emit;
         s1_interior_ff <= interior;
         s1_last_ff     <= last;
         s1_col_ff      <= col_ff[COL_W-1:0];
      end
   end

   // ---------------- window and decision ----------------
   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) win_in = {s1_bit_ff, rd_ff[0], rd_ff[1], win_ff[8:3]};

      trans = '0;
      ones  = '0;
      for (int i = 0; i < 8; i++) ring[i] = win_in[RING_POS[i]];
      for (int i = 0; i < 8; i++) begin
         trans = trans + 4'(!ring[i] && ring[(i + 1) % 8]);
         ones  = ones + 4'(ring[i]);
      end
      centre = win_in[POS_C];
      if (!sub_ff) begin
         prod1 = win_in[POS_N] & win_in[POS_E] & win_in[POS_S];
         prod2 = win_in[POS_E] & win_in[POS_S] & win_in[POS_W];
      end else begin
         prod1 = win_in[POS_N] & win_in[POS_E] & win_in[POS_W];
         prod2 = win_in[POS_N] & win_in[POS_S] & win_in[POS_W];
      end
      del = centre && s1_interior_ff && (trans == 4'd1) && (ones >= 4'd2)
          && (ones <= 4'd6) && !prod1 && !prod2;

      push = s1_valid_ff && s1_emit_ff;
      push_data.pixel_out     = centre & ~del;
      push_data.deleted       = del;
      push_data.last          = s1_last_ff;
      push_data.frame_changed = s1_last_ff & (any_ff | del);

      any_in = any_ff;
      if (restart) any_in = 1'b0;
      else if (push) any_in = s1_last_ff ? 1'b0 : (any_ff | del);
   end

   // ---------------- output queue ----------------
   always_comb begin
      rsp_valid = cnt_ff != '0;
      rsp_data  = fifo[rd_ptr_ff];
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) fifo[wr_ptr_ff] <= push_data;
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff      <= 1'b0;
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
         any_ff      <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         sub_ff      <= sub_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
         win_ff      <= win_in;
         any_ff      <= any_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### test/subpass_check_pkg.sv
// ----------------------------------------------------------------------------
// Thinning sub-pass scoreboard
// Keeps its own copy of the row stores, the 3x3 window, the frame counters and
// the sizes. It works out the pixel, if any, that each accepted input beat
// should release, queues it, and compares each result beat field by field
// against the oldest queued pixel.
// ----------------------------------------------------------------------------
`default_nettype none

package subpass_check_pkg;

   import bts_pkg::*;

   class subpass_pixel_predictor;

      bit          upper_row [MAX_WIDTH];
      bit          middle_row [MAX_WIDTH];
      logic [8:0]  window;
      int unsigned col_cnt;
      int unsigned row_cnt;
      int unsigned emitted;
      bit          any_del;
      bit          sub_iter;
      int unsigned width;
      int unsigned height;
      rsp_type     pending_pixels [$];
      int unsigned checked;
      int unsigned mismatches;

      function new();
         foreach (upper_row[i]) begin
            upper_row[i]  = 1'b0;
            middle_row[i] = 1'b0;
         end
         window     = '0;
         sub_iter   = 1'b0;
         width      = 32'(WIDTH_RESET);
         height     = 32'(HEIGHT_RESET);
         checked    = 0;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         col_cnt = 0;
         row_cnt = 0;
         emitted = 0;
         any_del = 1'b0;
      endfunction

      function int unsigned fit_size(logic [SIZE_W-1:0] value, int unsigned hi);
         if (value < MIN_SIZE) return MIN_SIZE;
         if (value > hi) return hi;
         return 32'(value);
      endfunction

      function void set_register(logic [CSR_W-1:0] idx, logic [SIZE_W-1:0] value);
         case (idx)
            CSR_SUB_ITERATION: sub_iter = value[0];
            CSR_IMAGE_WIDTH: begin
               width = fit_size(value, MAX_WIDTH);
               restart();
            end
            CSR_IMAGE_HEIGHT: begin
               height = fit_size(value, MAX_HEIGHT);
               restart();
            end
            default: ;
         endcase
      endfunction

      function int unsigned outstanding();
         return pending_pixels.size();
      endfunction

      function void take_pixel_beat(req_type beat);
         int unsigned r;
         int unsigned c;
         int unsigned er;
         int unsigned ec;
         int unsigned rises;
         bit          pix;
         bit          top;
         bit          mid;
         bit          centre;
         bit          drop;
         bit          hit;
         logic [7:0]  ring;
         rsp_type     outcome;
         r = row_cnt;
         c = col_cnt;
         if (r < height) begin
            if (beat.action == ACTION_DRAIN) return;
            pix = beat.pixel;
         end else begin
            pix = 1'b0;
         end
         top = upper_row[c];
         mid = middle_row[c];
         upper_row[c]  = mid;
         middle_row[c] = pix;
         window = {pix, mid, top, window[8:3]};
         col_cnt = c + 1;
         if (col_cnt >= width) begin
            col_cnt = 0;
            row_cnt = r + 1;
         end
         if (!(r >= 2 || (r == 1 && c >= 1))) return;
         if (c >= 1) begin
            er = r - 1;
            ec = c - 1;
         end else begin
            er = r - 2;
            ec = width - 1;
         end
         centre = window[4];
         drop   = 1'b0;
         if (centre && er >= 1 && er + 2 <= height && ec >= 1 && ec + 2 <= width) begin
            // ring from north, clockwise: N NE E SE S SW W NW
            ring  = {window[0], window[1], window[2], window[5],
                     window[8], window[7], window[6], window[3]};
            rises = 0;
            for (int i = 0; i < 8; i++) begin
               if (!ring[i] && ring[(i + 1) % 8]) rises++;
            end
            if (!sub_iter)
               hit = (ring[0] & ring[2] & ring[4]) | (ring[2] & ring[4] & ring[6]);
            else
               hit = (ring[0] & ring[2] & ring[6]) | (ring[0] & ring[4] & ring[6]);
            drop = (rises == 1) && ($countones(ring) >= 2) && ($countones(ring) <= 6)
                   && !hit;
         end
         if (drop) any_del = 1'b1;
         outcome.pixel_out     = centre & ~drop;
         outcome.deleted       = drop;
         outcome.last          = 1'b0;
         outcome.frame_changed = 1'b0;
         emitted++;
         if (emitted >= width * height) begin
            outcome.last          = 1'b1;
            outcome.frame_changed = any_del;
            restart();
         end
         pending_pixels.push_back(outcome);
      endfunction

      task note_mismatch(string msg);
         if (mismatches < 100) $display("mismatch at result %0d: %s", checked, msg);
         mismatches++;
      endtask

      task check_pixel_beat(rsp_type got);
         rsp_type want;
         if (pending_pixels.size() == 0) begin
            note_mismatch($sformatf("unexpected beat %b", got));
         end else begin
            want = pending_pixels.pop_front();
            if (got.pixel_out !== want.pixel_out)
               note_mismatch($sformatf("pixel_out %b, want %b", got.pixel_out,
                                       want.pixel_out));
            if (got.deleted !== want.deleted)
               note_mismatch($sformatf("deleted %b, want %b", got.deleted, want.deleted));
            if (got.last !== want.last)
               note_mismatch($sformatf("last %b, want %b", got.last, want.last));
            if (got.frame_changed !== want.frame_changed)
               note_mismatch($sformatf("frame_changed %b, want %b", got.frame_changed,
                                       want.frame_changed));
         end
         checked++;
      endtask

   endclass

endpackage

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// Binary thinning sub-pass testbench
// Streams binary frames through the block in raster order with their drain
// tails, mixes in ignored drains, pixels past the frame end, cut-off frames
// and size changes, and varies idle and stall pressure on both channels.
// Every result beat is checked against the scoreboard's own sub-pass model.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import bts_pkg::*;
   import subpass_check_pkg::*;

   localparam logic [CSR_W-1:0] CSR_SPARE   = 2'd3;
   localparam int unsigned      CYCLE_LIMIT = 1_000_000;
   localparam int unsigned      SMALL_ITEMS = 800;
   localparam logic [15:0]      FIRST_FRAME = 16'b0000_0110_0110_1001;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we    = 1'b0;
   logic [CSR_W-1:0]  csr_index = '0;
   logic [SIZE_W-1:0] csr_wdata = '0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycles         = 0;
   int unsigned counted        = 0;

   subpass_pixel_predictor board;

   binary_thinning_subpass_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (req_valid && req_ready) board.take_pixel_beat(req_data);
         if (rsp_valid && rsp_ready) board.check_pixel_beat(rsp_data);
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL binary_thinning_subpass_top");
         $finish;
      end
   end

   task automatic send_beat(input logic action, input logic pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{action: action, pixel: pix};
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_W-1:0] idx, input logic [SIZE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.set_register(idx, value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input int unsigned density, input bit noisy);
      int unsigned w;
      int unsigned h;
      w = board.width;
      h = board.height;
      for (int unsigned i = 0; i < w * h; i++) begin
         if (noisy && $urandom_range(99) < 4)
            send_beat(ACTION_DRAIN, 1'($urandom_range(1)));
         send_beat(ACTION_PIXEL, $urandom_range(99) < density);
      end
      // flush the tail; a pixel here counts as a drain
      for (int unsigned i = 0; i <= w; i++)
         send_beat(($urandom_range(9) < 2) ? ACTION_PIXEL : ACTION_DRAIN,
                   1'($urandom_range(1)));
      if (noisy && $urandom_range(9) == 0) send_beat(ACTION_DRAIN, 1'($urandom_range(1)));
   endtask

   initial begin
      int unsigned phase;
      int unsigned wv;
      int unsigned hv;
      int unsigned density;
      int unsigned frames;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_register(CSR_IMAGE_WIDTH, '0);
      write_register(CSR_IMAGE_HEIGHT, SIZE_W'(3));
      write_register(CSR_SUB_ITERATION, '0);
      send_beat(ACTION_DRAIN, 1'b1);
      for (int i = 0; i < 16; i++) begin
         if (i == 6) send_beat(ACTION_DRAIN, 1'b0);
         send_beat(ACTION_PIXEL, FIRST_FRAME[15 - i]);
      end
      send_beat(ACTION_PIXEL, 1'b1);
      repeat (4) send_beat(ACTION_DRAIN, 1'b0);
      send_beat(ACTION_DRAIN, 1'b1);
      settle();
      repeat (3) send_beat(ACTION_PIXEL, 1'b1);
      settle();
      write_register(CSR_SPARE, '1);

      phase = 0;
      while (counted < SMALL_ITEMS || phase < 6) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         wv = $urandom_range(12, 4);
         hv = $urandom_range(9, 4);
         if ($urandom_range(9) == 0) wv = $urandom_range(3);
         write_register(CSR_SUB_ITERATION, SIZE_W'(phase % 2));
         write_register(CSR_IMAGE_WIDTH, SIZE_W'(wv));
         write_register(CSR_IMAGE_HEIGHT, SIZE_W'(hv));
         frames = $urandom_range(3, 1);
         repeat (frames) begin
            case ($urandom_range(3))
               0: density = 15;
               1: density = 50;
               2: density = 70;
               default: density = 90;
            endcase
            send_frame(density, 1'b1);
            counted += board.width * (board.height + 1) + 1;
         end
         // cut a frame short; the next size write restarts it
         if ($urandom_range(4) == 0) begin
            frames = $urandom_range(board.width * board.height - 1, 1);
            repeat (frames) send_beat(ACTION_PIXEL, 1'($urandom_range(1)));
            counted += frames;
         end
         settle();
         phase++;
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (8) @(posedge clock);
      if (board.outstanding() != 0)
         board.note_mismatch($sformatf("%0d results never arrived", board.outstanding()));
      if (board.mismatches == 0)
         $display("PASS binary_thinning_subpass_top");
      else
         $display("FAIL binary_thinning_subpass_top");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
hw/rtl/bts_pkg.sv
hw/rtl/binary_thinning_subpass_top.sv
test/subpass_check_pkg.sv
test/testbench.sv
